@@ rtl/core/weno_face_interpolation_magnitude_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the face interpolation block
// ---------------------------------------------------------------------------
`ifndef WENO_FACE_INTERPOLATION_MAGNITUDE_DEFINES_SVH
`define WENO_FACE_INTERPOLATION_MAGNITUDE_DEFINES_SVH

// Checked outside reset.
`define WFIM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define WFIM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/wfim_pkg.sv @@
// ---------------------------------------------------------------------------
// wfim_pkg
// Shared types and constants of the face interpolation block.
// ---------------------------------------------------------------------------
`default_nettype none

package wfim_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int SMP_W            = 32;   // stored sample width
  localparam int QDEPTH           = 2;    // front-to-back queue depth
  localparam int CFG_W            = 16;

  localparam logic [1:0] CFG_SKIP  = 2'd0;
  localparam logic [1:0] CFG_FACES = 2'd1;
  localparam logic [1:0] CFG_EPS   = 2'd2;

  localparam logic [12:0] FACE_MAX    = 13'd4096;
  localparam logic [12:0] FACES_RESET = 13'd1024;

  typedef struct packed {
    logic [9:0]  skip;
    logic [12:0] faces;
    logic [15:0] eps;
  } cfg_t;

  typedef struct packed {
    logic [3:0][SMP_W-1:0] ay_win;   // [0] oldest
    logic [3:0][SMP_W-1:0] az_win;
    logic [11:0]           face_index;
    logic                  last_face;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/wfim_front.sv @@
// ---------------------------------------------------------------------------
// wfim_front
// Takes samples, tracks line position and window, queues face jobs.
// ---------------------------------------------------------------------------
`default_nettype none

module wfim_front #(
  parameter int SAMPLE_WIDTH = wfim_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wfim_pkg::cfg_t    cfg_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [63:0]       s_axis_tdata,   // ay_sample, az_sample
  input  wire logic              s_axis_tuser,   // line_start
  input  wire wfim_pkg::q_stat_t q_stat_i,
  output logic                   push_o,
  output wfim_pkg::job_t         job_o
);

  localparam int SW = wfim_pkg::SMP_W;
  localparam int SB = (SAMPLE_WIDTH < SW) ? SAMPLE_WIDTH : SW;

  logic                 acc;
  logic signed [SB-1:0] ay_raw, az_raw;
  logic [SW-1:0]        ay_ext, az_ext;
  logic [15:0]          sc_q, sc_d, sc;
  logic [12:0]          fd_q, fd_d, fd, faces;
  logic [2:0][SW-1:0]   wy_q, wy_d, wy, wz_q, wz_d, wz;

  assign s_axis_tready = !q_stat_i.full;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign ay_raw        = s_axis_tdata[SB-1:0];
  assign az_raw        = s_axis_tdata[32+SB-1:32];
  assign ay_ext        = SW'(ay_raw);
  assign az_ext        = SW'(az_raw);
  assign faces         = (cfg_i.faces > wfim_pkg::FACE_MAX) ? wfim_pkg::FACE_MAX : cfg_i.faces;

  always_comb begin
    sc     = s_axis_tuser ? '0 : sc_q;
    fd     = s_axis_tuser ? '0 : fd_q;
    wy     = s_axis_tuser ? '0 : wy_q;
    wz     = s_axis_tuser ? '0 : wz_q;
    sc_d   = sc_q;
    fd_d   = fd_q;
    wy_d   = wy_q;
    wz_d   = wz_q;
    push_o = 1'b0;
    job_o.ay_win     = {ay_ext, wy[2], wy[1], wy[0]};
    job_o.az_win     = {az_ext, wz[2], wz[1], wz[0]};
    job_o.face_index = fd[11:0];
    job_o.last_face  = (fd + 13'd1) == faces;
    if (acc) begin
      sc_d = sc;
      fd_d = fd;
      wy_d = wy;
      wz_d = wz;
      if (fd < faces) begin
        if (sc != 16'hFFFF) begin
          sc_d = sc + 16'd1;
        end
        if ({1'b0, sc} >= {7'd0, cfg_i.skip}) begin
          if ({1'b0, sc} >= ({7'd0, cfg_i.skip} + 17'd3)) begin
            push_o = 1'b1;
            fd_d   = fd + 13'd1;
          end
          wy_d = {ay_ext, wy[2], wy[1]};
          wz_d = {az_ext, wz[2], wz[1]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= '0;
      fd_q <= '0;
      wy_q <= '0;
      wz_q <= '0;
    end else begin
      sc_q <= sc_d;
      fd_q <= fd_d;
      wy_q <= wy_d;
      wz_q <= wz_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wfim_fifo.sv @@
// ---------------------------------------------------------------------------
// wfim_fifo
// Short job queue between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module wfim_fifo #(
  parameter int DEPTH = wfim_pkg::QDEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire wfim_pkg::job_t job_i,
  input  wire logic           pop_i,
  output wfim_pkg::job_t      job_o,
  output wfim_pkg::q_stat_t   stat_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wfim_pkg::job_t mem_q [DEPTH];
  logic [AW-1:0]  wp_q, rp_q;
  logic [CW-1:0]  cnt_q;

  assign job_o        = mem_q[rp_q];
  assign stat_o.full  = cnt_q == CW'(DEPTH);
  assign stat_o.empty = cnt_q == '0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
      end
      if (pop_i) begin
        rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wfim_back.sv @@
// ---------------------------------------------------------------------------
// wfim_back
// Sequenced datapath: indicators, weight division, blend, squares.
// ---------------------------------------------------------------------------
`default_nettype none

module wfim_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wfim_pkg::cfg_t    cfg_i,
  input  wire wfim_pkg::q_stat_t q_stat_i,
  input  wire wfim_pkg::job_t    job_i,
  output logic                   pop_o,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [79:0]            m_axis_tdata,   // potential_sq, face_index
  output logic                   m_axis_tlast    // last_face
);

  localparam int NW  = 37;   // candidate numerators, signed
  localparam int MW  = 36;   // multiplier operand
  localparam int PW  = 2 * MW;
  localparam int A6W = 38;
  localparam int DVW = 39;   // divide-by-six dividend
  localparam int RSH = 36;   // reciprocal shift for the divide by six

  // ceil(2^36 / 6): exact quotient for every dividend below 2^35
  localparam logic [MW-1:0] RECIP6 = 36'd11453246123;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PREP  = 4'd1;
  localparam logic [3:0] ST_IND   = 4'd2;
  localparam logic [3:0] ST_NORM  = 4'd3;
  localparam logic [3:0] ST_SQ    = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_BLEND = 4'd6;
  localparam logic [3:0] ST_D6    = 4'd7;
  localparam logic [3:0] ST_SQV   = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [3:0]            state_q;
  logic [2:0]            step_q;
  logic [5:0]            cnt_q;
  logic                  comp_q;
  wfim_pkg::job_t        job_q;
  logic signed [NW-1:0]  nl_q, diff_q;
  logic [33:0]           mcl_q, mcr_q;
  logic [32:0]           mdl_q, mdr_q;
  logic                  negl_q, negr_q;
  logic [PW-1:0]         accl_q, accr_q, prod_q;
  logic [63:0]           den_q, rem_q, sy_q, res_q;
  logic [32:0]           wr_q;
  logic [DVW-1:0]        m_q;

  // window of the component in work
  logic [3:0][31:0]      fsel;
  logic signed [NW-1:0]  e1, e2, e3, e4, nl, nr, cl, dl, cr, dr;
  logic [NW-1:0]         acl, adl, acr, adr, adiff;
  logic [15:0]           eps;
  logic [PW-1:0]         eps12, p3, p6;
  logic [MW-1:0]         op_a, op_b;
  logic [64:0]           r2;
  logic [PW-1:0]         tsum;
  logic [A6W-1:0]        stp, a6, aa6;
  logic [64:0]           sum;

  assign fsel  = comp_q ? job_q.az_win : job_q.ay_win;
  assign e1    = NW'($signed(fsel[0]));
  assign e2    = NW'($signed(fsel[1]));
  assign e3    = NW'($signed(fsel[2]));
  assign e4    = NW'($signed(fsel[3]));
  assign nl    = (e2 <<< 2) + e2 + (e3 <<< 1) - e1;
  assign nr    = (e2 <<< 1) + (e3 <<< 2) + e3 - e4;
  assign cl    = e1 - (e2 <<< 1) + e3;
  assign dl    = e3 - e1;
  assign cr    = e2 - (e3 <<< 1) + e4;
  assign dr    = e4 - e2;
  assign acl   = cl[NW-1] ? -cl : cl;
  assign adl   = dl[NW-1] ? -dl : dl;
  assign acr   = cr[NW-1] ? -cr : cr;
  assign adr   = dr[NW-1] ? -dr : dr;
  assign adiff = diff_q[NW-1] ? -diff_q : diff_q;
  assign eps   = (cfg_i.eps == '0) ? 16'd1 : cfg_i.eps;
  assign eps12 = PW'({eps, 3'b000}) + PW'({eps, 2'b00});
  assign p3    = prod_q + (prod_q << 1);
  assign p6    = (prod_q << 2) + (prod_q << 1);
  assign r2    = {rem_q, 1'b0};
  assign tsum  = prod_q + (PW'(1) << 31);
  assign stp   = tsum[32 +: A6W];
  assign a6    = diff_q[NW-1] ? A6W'(nl_q) - stp : A6W'(nl_q) + stp;
  assign aa6   = a6[A6W-1] ? -a6 : a6;
  assign sum   = {1'b0, sy_q} + {1'b0, prod_q[63:0]};
  assign pop_o = (state_q == ST_IDLE) && !q_stat_i.empty;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      ST_IND: begin
        case (step_q)
          3'd0: begin op_a = MW'(mcl_q); op_b = MW'(mcl_q); end
          3'd1: begin op_a = MW'(mdl_q); op_b = MW'(mdl_q); end
          3'd2: begin op_a = MW'(mcl_q); op_b = MW'(mdl_q); end
          3'd3: begin op_a = MW'(mcr_q); op_b = MW'(mcr_q); end
          3'd4: begin op_a = MW'(mdr_q); op_b = MW'(mdr_q); end
          3'd5: begin op_a = MW'(mcr_q); op_b = MW'(mdr_q); end
          default: ;
        endcase
      end
      ST_SQ: begin
        if (step_q == 3'd0) begin
          op_a = MW'(accl_q[30:0]);
          op_b = MW'(accl_q[30:0]);
        end else begin
          op_a = MW'(accr_q[30:0]);
          op_b = MW'(accr_q[30:0]);
        end
      end
      ST_BLEND: begin
        op_a = MW'(wr_q);
        op_b = adiff[MW-1:0];
      end
      ST_D6: begin
        op_a = m_q[MW-1:0];
        op_b = RECIP6;
      end
      ST_SQV: begin
        op_a = m_q[MW-1:0];
        op_b = m_q[MW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          job_q <= job_i;
        end
      end
      ST_PREP: begin
        nl_q   <= nl;
        diff_q <= nr - nl;
        mcl_q  <= acl[33:0];
        mdl_q  <= adl[32:0];
        mcr_q  <= acr[33:0];
        mdr_q  <= adr[32:0];
        negl_q <= cl[NW-1] ^ dl[NW-1];
        negr_q <= ~(cr[NW-1] ^ dr[NW-1]);
        accl_q <= eps12;
        accr_q <= eps12;
      end
      ST_IND: begin
        case (step_q)
          3'd1: accl_q <= accl_q + (prod_q << 4);
          3'd2: accl_q <= accl_q + p3;
          3'd3: accl_q <= negl_q ? accl_q - p6 : accl_q + p6;
          3'd4: accr_q <= accr_q + (prod_q << 4);
          3'd5: accr_q <= accr_q + p3;
          3'd6: accr_q <= negr_q ? accr_q - p6 : accr_q + p6;
          default: ;
        endcase
      end
      ST_NORM: begin
        // common shift until the larger indicator is below 2^31
        if ((|accl_q[PW-1:31]) || (|accr_q[PW-1:31])) begin
          accl_q <= accl_q >> 1;
          accr_q <= accr_q >> 1;
        end
      end
      ST_SQ: begin
        if (step_q == 3'd1) begin
          rem_q <= prod_q[63:0];
        end else if (step_q == 3'd2) begin
          den_q <= rem_q + prod_q[63:0];
          wr_q  <= (prod_q[63:0] == '0) ? (33'd1 << 32) : '0;
        end
      end
      ST_DIV: begin
        if (r2 >= {1'b0, den_q}) begin
          rem_q <= 64'(r2 - {1'b0, den_q});
          wr_q  <= {wr_q[31:0], 1'b1};
        end else begin
          rem_q <= r2[63:0];
          wr_q  <= {wr_q[31:0], 1'b0};
        end
      end
      ST_BLEND: begin
        if (step_q == 3'd1) begin
          m_q <= DVW'(aa6) + DVW'(3);
        end
      end
      ST_D6: begin
        if (step_q == 3'd1) begin
          m_q <= DVW'(prod_q[PW-1:RSH]);
        end
      end
      ST_SQV: begin
        if (step_q == 3'd1) begin
          if (!comp_q) begin
            sy_q <= prod_q[63:0];
          end else begin
            res_q <= sum[64] ? '1 : sum[63:0];
          end
        end
      end
      ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= {4'd0, job_q.face_index, res_q};
          m_axis_tlast <= job_q.last_face;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      step_q        <= '0;
      cnt_q         <= '0;
      comp_q        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state_q != ST_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!q_stat_i.empty) begin
            comp_q  <= 1'b0;
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          step_q  <= '0;
          state_q <= ST_IND;
        end
        ST_IND: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd6) begin
            state_q <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (!((|accl_q[PW-1:31]) || (|accr_q[PW-1:31]))) begin
            step_q  <= '0;
            state_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          cnt_q <= '0;
          if (step_q == 3'd2) begin
            step_q  <= '0;
            state_q <= (prod_q[63:0] == '0) ? ST_BLEND : ST_DIV;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) begin
            step_q  <= '0;
            state_q <= ST_BLEND;
          end
        end
        ST_BLEND: begin
          if (step_q == 3'd1) begin
            step_q  <= '0;
            state_q <= ST_D6;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        ST_D6: begin
          if (step_q == 3'd1) begin
            step_q  <= '0;
            state_q <= ST_SQV;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        ST_SQV: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd1) begin
            if (!comp_q) begin
              comp_q  <= 1'b1;
              state_q <= ST_PREP;
            end else begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/weno_face_interpolation_magnitude.sv @@
// ---------------------------------------------------------------------------
// weno_face_interpolation_magnitude
// Third-order weighted face interpolation of (ay, az), squared magnitude.
// ---------------------------------------------------------------------------
// Input stream s_axis: one (ay, az) Q16.16 pair per transfer, tuser marks the
// first sample of a grid line. Output stream m_axis: one Q32.32 ay^2 + az^2
// per face with its face index, tlast on the final face of the line.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 skip_count, 1 face_count, 2 epsilon); write only while idle.
// Samples that produce no face are taken whenever the queue is not full. A
// face is computed by one shared 36x36 multiplier sequenced per component:
// indicators, normalizing shift, squares, a 32-step weight division
// (skipped when the right indicator squares to zero), blend, a reciprocal
// multiply for the divide by six and the final square. The job is taken
// from the queue before the first component and the result is presented
// after the second.
// A two-entry queue decouples the input side from the arithmetic.
// Reset clears the line position and window and loads the register defaults.
// While the receiver stalls the result holds; the queue fills and then the
// input deasserts tready.
// ---------------------------------------------------------------------------
`default_nettype none

module weno_face_interpolation_magnitude #(
  parameter int SAMPLE_WIDTH = wfim_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_idx_i,
  input  wire logic [wfim_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [63:0]                s_axis_tdata,   // ay_sample, az_sample
  input  wire logic                       s_axis_tuser,   // line_start
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [79:0]                     m_axis_tdata,   // potential_sq, face_index
  output logic                            m_axis_tlast    // last_face
);

  wfim_pkg::cfg_t    cfg_q;
  wfim_pkg::q_stat_t q_stat;
  wfim_pkg::job_t    push_job, pop_job;
  logic              push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.skip  <= '0;
      cfg_q.faces <= wfim_pkg::FACES_RESET;
      cfg_q.eps   <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wfim_pkg::CFG_SKIP:  cfg_q.skip  <= cfg_data_i[9:0];
        wfim_pkg::CFG_FACES: cfg_q.faces <= cfg_data_i[12:0];
        wfim_pkg::CFG_EPS:   cfg_q.eps   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wfim_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i         (cfg_q),
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .q_stat_i      (q_stat),
    .push_o        (push),
    .job_o         (push_job)
  );

  wfim_fifo #(
    .DEPTH(wfim_pkg::QDEPTH)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (pop_job),
    .stat_o (q_stat)
  );

  wfim_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i    (cfg_q),
    .q_stat_i (q_stat),
    .job_i    (pop_job),
    .pop_o    (pop),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

endmodule

`default_nettype wire

@@ rtl/core/wfim_chk.sv @@
// ---------------------------------------------------------------------------
// wfim_chk
// Port-level checks on the result stream.
// ---------------------------------------------------------------------------
`default_nettype none

`include "weno_face_interpolation_magnitude_defines.svh"

module wfim_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [79:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  logic        stall;
  logic [80:0] beat;

  assign stall = m_axis_tvalid && !m_axis_tready;
  assign beat  = {m_axis_tlast, m_axis_tdata};

  `WFIM_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !m_axis_tvalid, "result during reset")
  `WFIM_ASSERT(a_stall_hold, stall |=> m_axis_tvalid && $stable(beat), "stalled result changed")
  `WFIM_ASSERT(a_known_beat, m_axis_tvalid |-> !$isunknown(beat), "unknown result bits")

endmodule

bind weno_face_interpolation_magnitude wfim_chk u_wfim_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ dv/weno_face_interpolation_magnitude_tb.sv @@
// ----------------------------------------------------------------------------
// weno_face_interpolation_magnitude_tb
// Self-checking stream test of the WENO face interpolation magnitude block.
// ----------------------------------------------------------------------------
// Drives grid lines of (ay, az) pairs, predicts each face result with an
// independent fixed-point model and compares every output transfer in order.
// Covers register extremes, line over, zero faces, skip changes mid line,
// long output stalls and random lines with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module weno_face_interpolation_magnitude_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 600;

  typedef struct {
    logic [63:0] mag_sq;
    logic [11:0] index;
    logic        last;
  } face_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = wfim_pkg::CFG_SKIP;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic [63:0] s_tdata = '0;   // ay_sample, az_sample
  logic        s_tuser = 1'b0; // line_start
  logic        m_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [79:0] m_axis_tdata;   // potential_sq, face_index
  wire         m_axis_tlast;   // last_face

  weno_face_interpolation_magnitude dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // predictor state
  int unsigned  skip_reg = 0, faces_reg = wfim_pkg::FACES_RESET, eps_reg = 1;
  longint       ay_hist[3], az_hist[3];
  int unsigned  line_pos = 0, faces_out = 0;
  face_t        pending_faces[$];
  int           errors = 0;
  bit           tx_idle = 1'b0, rx_idle = 1'b0;
  bit           hold_req = 1'b0;
  int           hold_cnt = 0, rx_wait = 0, quiet_cycles = 0;

  function automatic longint weno_blend(longint f1, longint f2, longint f3, longint f4,
                                        longint unsigned eps);
    longint nl, nr, diff, a6, cl, dl, cr, dr;
    logic signed [127:0] e12, lw, rw, big;
    logic [127:0] t, quo;
    logic [63:0] pl, pr, ql, qr, den, wr, mag, q;
    int len, sh;
    nl = -f1 + 5 * f2 + 2 * f3;
    nr = 2 * f2 + 5 * f3 - f4;
    cl = f1 - 2 * f2 + f3;
    dl = f3 - f1;
    cr = f2 - 2 * f3 + f4;
    dr = f4 - f2;
    e12 = 128'sd12 * $signed({64'd0, eps});
    // indicators are positive definite, so exact signed math is safe
    lw = 128'sd16 * cl * cl + 128'sd6 * cl * dl + 128'sd3 * dl * dl + e12;
    rw = 128'sd16 * cr * cr - 128'sd6 * cr * dr + 128'sd3 * dr * dr + e12;
    big = (lw < rw) ? rw : lw;
    len = 0;
    for (int i = 0; i < 128; i++) if (big[i]) len = i + 1;
    sh = (len > 31) ? len - 31 : 0;
    pl = 64'(lw >>> sh);
    pr = 64'(rw >>> sh);
    ql = pl * pl;
    qr = pr * pr;
    den = ql + qr;
    if (ql >= den) begin
      wr = 64'd1 << 32;
    end else begin
      quo = ({64'd0, ql} << 32) / {64'd0, den};
      wr = quo[63:0];
    end
    diff = nr - nl;
    mag = (diff < 0) ? -diff : diff;
    t = {64'd0, wr} * {64'd0, mag} + (128'd1 << 31);
    a6 = (diff < 0) ? nl - longint'(t[95:32]) : nl + longint'(t[95:32]);
    q = ((a6 < 0) ? 64'(-a6) : 64'(a6)) + 64'd3;
    q = q / 64'd6;
    return (a6 < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void take_sample(logic [31:0] ay, logic [31:0] az, logic start);
    int unsigned lim, pos;
    longint unsigned eps, my, mz, sy, sz;
    longint vy, vz;
    logic [64:0] total;
    face_t f;
    lim = (faces_reg > 4096) ? 4096 : faces_reg;
    eps = (eps_reg == 0) ? 1 : eps_reg;
    if (start) begin
      line_pos = 0;
      faces_out = 0;
      for (int i = 0; i < 3; i++) begin
        ay_hist[i] = 0;
        az_hist[i] = 0;
      end
    end
    if (faces_out >= lim) return;
    pos = line_pos;
    if (line_pos < 65535) line_pos++;
    if (pos < skip_reg) return;
    if (pos >= skip_reg + 3) begin
      vy = weno_blend(ay_hist[0], ay_hist[1], ay_hist[2], longint'($signed(ay)), eps);
      vz = weno_blend(az_hist[0], az_hist[1], az_hist[2], longint'($signed(az)), eps);
      my = (vy < 0) ? -vy : vy;
      mz = (vz < 0) ? -vz : vz;
      sy = my * my;  // wraps like the 64-bit square
      sz = mz * mz;
      total = {1'b0, sy} + {1'b0, sz};
      f.mag_sq = total[64] ? '1 : total[63:0];
      f.index = faces_out[11:0];
      f.last = (faces_out + 1 == lim);
      pending_faces = {pending_faces, f};
      faces_out++;
    end
    ay_hist[0] = ay_hist[1]; ay_hist[1] = ay_hist[2]; ay_hist[2] = longint'($signed(ay));
    az_hist[0] = az_hist[1]; az_hist[1] = az_hist[2]; az_hist[2] = longint'($signed(az));
  endfunction

  // input monitor feeds the predictor, output monitor checks
  always @(posedge clk_i) begin
    face_t f;
    if (rst_ni && s_tvalid && s_axis_tready) take_sample(s_tdata[31:0], s_tdata[63:32], s_tuser);
    if (rst_ni && m_axis_tvalid && m_tready) begin
      if (pending_faces.size() == 0) begin
        errors++;
        $display("%0t: unexpected face result %h", $realtime, m_axis_tdata);
      end else begin
        f = pending_faces.pop_front();
        if (m_axis_tdata[63:0] !== f.mag_sq) begin
          errors++;
          $display("%0t: potential_sq exp %h got %h", $realtime, f.mag_sq, m_axis_tdata[63:0]);
        end
        if (m_axis_tdata[75:64] !== f.index) begin
          errors++;
          $display("%0t: face_index exp %0d got %0d", $realtime, f.index, m_axis_tdata[75:64]);
        end
        if (m_axis_tlast !== f.last) begin
          errors++;
          $display("%0t: last_face exp %b got %b", $realtime, f.last, m_axis_tlast);
        end
      end
    end
  end

  // receiver: random gap after each transfer, long hold on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 3000;
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= (hold_cnt == 0);
    end else if (m_tready && m_axis_tvalid) begin
      rx_wait = rx_idle ? $urandom_range(0, 18) : 0;
      if (rx_wait > 0) m_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      if (rx_wait == 0) m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_sample(logic [31:0] ay, logic [31:0] az, logic start);
    int gap;
    gap = tx_idle ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {az, ay};
    s_tuser <= start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_faces.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value[15:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (idx)
      wfim_pkg::CFG_SKIP:  skip_reg = value & 32'h3FF;
      wfim_pkg::CFG_FACES: faces_reg = value & 32'h1FFF;
      wfim_pkg::CFG_EPS:   eps_reg = value & 32'hFFFF;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_sample(int mode, int pos);
    logic [31:0] corner[5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1};
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000);
      2: return 32'(pos * 32'h1_8000 + $urandom_range(0, 255));
      default: return corner[$urandom_range(0, 4)];
    endcase
  endfunction

  task automatic send_line(int n, int mode);
    for (int i = 0; i < n; i++)
      send_sample(pick_sample(mode, i), pick_sample(mode, i), i == 0);
  endtask

  task automatic test_reset_line();
    // reset counts as a line start, so no tuser here
    logic [31:0] v[8] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000};
    for (int i = 0; i < 8; i++) send_sample(v[i], v[7 - i], 1'b0);
    drain();
  endtask

  task automatic test_epsilon_extremes();
    write_reg(wfim_pkg::CFG_EPS, 0);
    send_line(6, 3);
    drain();
    write_reg(wfim_pkg::CFG_EPS, 65535);
    send_line(6, 1);
    drain();
  endtask

  task automatic test_line_over();
    write_reg(wfim_pkg::CFG_FACES, 3);
    write_reg(wfim_pkg::CFG_SKIP, 2);
    send_line(10, 0);
    send_line(7, 2);
    drain();
  endtask

  task automatic test_face_count_edges();
    write_reg(wfim_pkg::CFG_FACES, 0);
    send_line(6, 0);
    drain();
    write_reg(wfim_pkg::CFG_FACES, 8191);
    write_reg(wfim_pkg::CFG_SKIP, 0);
    send_line(6, 0);
    drain();
  endtask

  task automatic test_skip_mid_line();
    write_reg(wfim_pkg::CFG_FACES, 20);
    write_reg(wfim_pkg::CFG_SKIP, 1);
    send_line(5, 1);
    drain();
    write_reg(wfim_pkg::CFG_SKIP, 4);
    for (int i = 0; i < 5; i++) send_sample(pick_sample(1, i), pick_sample(0, i), 1'b0);
    drain();
  endtask

  task automatic test_skip_max();
    // whole line stays inside the skipped region
    write_reg(wfim_pkg::CFG_SKIP, 1023);
    write_reg(wfim_pkg::CFG_FACES, 2);
    tx_idle = 1'b0;
    send_line(40, 0);
    drain();
  endtask

  task automatic test_output_stall();
    write_reg(wfim_pkg::CFG_SKIP, 0);
    write_reg(wfim_pkg::CFG_FACES, 40);
    tx_idle = 1'b0;
    @(posedge clk_i);
    hold_req = 1'b1;
    send_line(16, 0);
    drain();
  endtask

  task automatic test_random_lines();
    int sent;
    int n;
    sent = 0;
    while (sent < 480) begin
      write_reg(wfim_pkg::CFG_SKIP, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12)
                                                                : $urandom_range(0, 3));
      write_reg(wfim_pkg::CFG_FACES, $urandom_range(1, 24));
      write_reg(wfim_pkg::CFG_EPS, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                               : $urandom_range(1, 64));
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      for (int k = 0; k < 4; k++) begin
        n = skip_reg + 3 + $urandom_range(0, faces_reg + 2);
        // occasionally break the line with an early restart
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
        send_line(n, $urandom_range(0, 3));
        sent += n;
      end
      drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_line();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    test_epsilon_extremes();
    test_line_over();
    test_face_count_edges();
    test_skip_mid_line();
    test_skip_max();
    test_output_stall();
    test_random_lines();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
